>>> rtl/core/sld_pkg.sv
`default_nettype none

package sld_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

  typedef logic [1:0] status_t;

  localparam status_t ST_DATA    = 2'd0;
  localparam status_t ST_BADSUM  = 2'd1;
  localparam status_t ST_EMPTY   = 2'd2;
  localparam status_t ST_TOOLONG = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic    ld_len;
    logic    ld_data;
    logic    emit_status;
    status_t status_code;
    logic    start_release;
    logic    rd_en;
    logic    emit_data;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_sync;
    logic rx_zero;
    logic too_long;
    logic data_done;
    logic check_ok;
    logic len_zero;
    logic last_k;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/sld_if.sv
`default_nettype none

interface sld_in_if;
  import sld_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sld_out_if;
  import sld_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic [IDX_W-1:0]  byte_index;
  status_t           status;
  logic              last;

  modport source (output valid, output payload_byte, output byte_index, output status,
                  output last, input ready);
  modport sink   (input valid, input payload_byte, input byte_index, input status,
                  input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sld_ctrl.sv
`default_nettype none

module sld_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sld_pkg::dp_stat_t stat,
  output sld_pkg::ctrl_cmd_t     cmd
);
  import sld_pkg::*;

  localparam logic [2:0] S_SYNC1 = 3'd0;
  localparam logic [2:0] S_SYNC2 = 3'd1;
  localparam logic [2:0] S_LEN   = 3'd2;
  localparam logic [2:0] S_DATA  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_WR    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       parse_state;
  logic       accept;

  assign parse_state = (state_r inside {S_SYNC1, S_SYNC2, S_LEN, S_DATA, S_CHECK});
  assign in_ready    = parse_state && stat.out_free;
  assign accept      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status_code = ST_DATA;
    case (state_r)
      S_SYNC1: begin
        if (accept && stat.is_sync) state_nxt = S_SYNC2;
      end
      S_SYNC2: begin
        if (accept) state_nxt = stat.is_sync ? S_LEN : S_SYNC1;
      end
      S_LEN: begin
        if (accept) begin
          cmd.ld_len = 1'b1;
          if (stat.too_long) begin
            cmd.emit_status = 1'b1;
            cmd.status_code = ST_TOOLONG;
            state_nxt = S_SYNC1;
          end else if (stat.rx_zero) begin
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (accept) begin
          cmd.ld_data = 1'b1;
          if (stat.data_done) state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (accept) begin
          if (!stat.check_ok) begin
            cmd.emit_status = 1'b1;
            cmd.status_code = ST_BADSUM;
            state_nxt = S_SYNC1;
          end else if (stat.len_zero) begin
            cmd.emit_status = 1'b1;
            cmd.status_code = ST_EMPTY;
            state_nxt = S_SYNC1;
          end else begin
            cmd.start_release = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        // store read data is held until the output slot frees
        if (stat.out_free) begin
          cmd.emit_data = 1'b1;
          state_nxt = stat.last_k ? S_SYNC1 : S_RD;
        end
      end
      default: begin
        state_nxt = S_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SYNC1;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sld_datapath.sv
`default_nettype none

module sld_datapath #(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [sld_pkg::BYTE_W-1:0] rx_byte,
  input  wire sld_pkg::ctrl_cmd_t         cmd,
  output sld_pkg::dp_stat_t               stat,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [sld_pkg::BYTE_W-1:0]      out_payload_byte,
  output logic [sld_pkg::IDX_W-1:0]       out_byte_index,
  output sld_pkg::status_t                out_status,
  output logic                            out_last
);
  import sld_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  logic [BYTE_W-1:0] store [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rd_data_r;

  logic [CW-1:0]     len_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_inc;
  logic [BYTE_W-1:0] check_r;
  logic [AW-1:0]     k_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_payload_r;
  logic [IDX_W-1:0]  out_index_r;
  status_t           out_status_r;
  logic              out_last_r;

  assign count_inc = count_r + CW'(1);

  always_comb begin
    stat.is_sync   = (rx_byte == SYNC_BYTE);
    stat.rx_zero   = (rx_byte == '0);
    stat.too_long  = (rx_byte > BYTE_W'(MAX_PAYLOAD));
    stat.data_done = (count_inc >= len_r);
    stat.check_ok  = (check_r == rx_byte);
    stat.len_zero  = (len_r == '0);
    stat.last_k    = ((CW'(k_r) + CW'(1)) == len_r);
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      count_r <= '0;
      check_r <= '0;
      k_r     <= '0;
    end else begin
      if (cmd.ld_len) begin
        len_r   <= rx_byte[CW-1:0];
        count_r <= '0;
        check_r <= rx_byte;
      end
      if (cmd.ld_data) begin
        count_r <= count_inc;
        check_r <= check_r ^ rx_byte;
      end
      if (cmd.start_release) begin
        k_r <= '0;
      end else if (cmd.emit_data) begin
        k_r <= k_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_data && (count_r < CW'(MAX_PAYLOAD))) begin
      store[count_r[AW-1:0]] <= rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= store[k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_status || cmd.emit_data) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_status) begin
      out_payload_r <= '0;
      out_index_r   <= '0;
      out_status_r  <= cmd.status_code;
      out_last_r    <= 1'b1;
    end else if (cmd.emit_data) begin
      out_payload_r <= rd_data_r;
      out_index_r   <= IDX_W'(k_r);
      out_status_r  <= ST_DATA;
      out_last_r    <= stat.last_k;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_payload_r;
  assign out_byte_index   = out_index_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

>>> rtl/core/sync_length_xor_deframer_core.sv
// Timing: a status result is presented in the cycle after the byte that causes it is transferred;
// the first payload byte of a verified frame passes S_RD, S_WR and the output register after the
// check byte. Throughput: one received byte per cycle while the output slot is free, but not during
// a release, which steps S_RD then S_WR per payload byte for the registered read port of the store.
// Reset: synchronous, active low; clears the parser and output valid, the store is not cleared.
`default_nettype none

module sync_length_xor_deframer_core #(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sld_in_if.sink     in_if,
  sld_out_if.source  out_if
);
  import sld_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  sld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sld_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .rx_byte          (in_if.rx_byte),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_payload_byte (out_if.payload_byte),
    .out_byte_index   (out_if.byte_index),
    .out_status       (out_if.status),
    .out_last         (out_if.last)
  );

  assign in_if.ready = in_ready;

`ifndef NO_ASSERTIONS
  // a status result stands alone
  a_status_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status != ST_DATA)) |-> out_if.last)
    else $error("status result without last");

  a_status_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status != ST_DATA)) |->
    ((out_if.payload_byte == '0) && (out_if.byte_index == '0)))
    else $error("status result with nonzero payload");

  // a stalled result must not be overwritten by a new transfer
  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |-> !in_if.ready)
    else $error("input ready while output stalled");

  // no input is taken in the middle of a frame release
  a_burst_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status == ST_DATA) && !out_if.last) |-> !in_if.ready)
    else $error("input ready during release");
`endif

endmodule

`default_nettype wire

>>> tb/sync_length_xor_deframer_core_tb.sv
`default_nettype none

module sync_length_xor_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sld_pkg::*;

  localparam int MAX_PAYLOAD = 64;
  localparam int N_ITEMS     = 180;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 20;

  typedef enum logic [2:0] {
    PH_SYNC1, PH_SYNC2, PH_LEN, PH_DATA, PH_CHECK
  } parse_phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic [IDX_W-1:0]  byte_index;
    status_t           status;
    logic              last;
  } deframed_t;

  typedef struct {
    logic [BYTE_W-1:0] rx;
    bit                typed;
    status_t           st;
  } stim_row_t;

  logic clk;
  logic rst_n;

  sld_in_if  in_ch ();
  sld_out_if out_ch ();

  sync_length_xor_deframer_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // deframer state as the link would see it
  parse_phase_e      rx_phase;
  logic [7:0]        hdr_len;
  logic [6:0]        bytes_seen;
  logic [7:0]        xor_sum;
  logic [BYTE_W-1:0] frame_buf [MAX_PAYLOAD];

  deframed_t released_q [$];
  deframed_t awaited_q [$];

  int mismatches  = 0;
  int burst_left  = 0;
  int live_items  = 0;
  int idle_cycles = 0;

  // directed opening: typed rows carry a status that is plain from the frame bytes
  stim_row_t directed_rows [24] = '{
    '{8'hFF, 1'b0, ST_DATA}, '{8'hFF, 1'b0, ST_DATA},
    '{8'h00, 1'b0, ST_DATA}, '{8'h00, 1'b1, ST_EMPTY},
    '{8'hFF, 1'b0, ST_DATA}, '{8'hFF, 1'b0, ST_DATA}, '{8'h41, 1'b1, ST_TOOLONG},
    '{8'hFF, 1'b0, ST_DATA}, '{8'hFF, 1'b0, ST_DATA}, '{8'hFF, 1'b1, ST_TOOLONG},
    // missing second sync, then a zero that must not count as a sync
    '{8'hFF, 1'b0, ST_DATA}, '{8'h00, 1'b0, ST_DATA}, '{8'h00, 1'b0, ST_DATA},
    '{8'hFF, 1'b0, ST_DATA}, '{8'hFF, 1'b0, ST_DATA}, '{8'h01, 1'b0, ST_DATA},
    '{8'hA5, 1'b0, ST_DATA}, '{8'hA4, 1'b0, ST_DATA},
    '{8'hFF, 1'b0, ST_DATA}, '{8'hFF, 1'b0, ST_DATA}, '{8'h02, 1'b0, ST_DATA},
    '{8'hFF, 1'b0, ST_DATA}, '{8'h00, 1'b0, ST_DATA}, '{8'h00, 1'b1, ST_BADSUM}
  };

  function automatic deframed_t status_result(input status_t code);
    deframed_t r;
    r.payload_byte = '0;
    r.byte_index   = '0;
    r.status       = code;
    r.last         = 1'b1;
    return r;
  endfunction

  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    deframed_t r;
    int        n;
    released_q.delete();
    case (rx_phase)
      PH_SYNC1: if (b == SYNC_BYTE) rx_phase = PH_SYNC2;
      PH_SYNC2: rx_phase = (b == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
      PH_LEN: begin
        hdr_len    = b;
        bytes_seen = '0;
        xor_sum    = b;
        if (b > MAX_PAYLOAD) begin
          rx_phase = PH_SYNC1;
          released_q.push_back(status_result(ST_TOOLONG));
        end else begin
          rx_phase = (b == 8'd0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        if (bytes_seen < MAX_PAYLOAD) frame_buf[bytes_seen[IDX_W-1:0]] = b;
        bytes_seen = bytes_seen + 7'd1;
        xor_sum    = xor_sum ^ b;
        if ({1'b0, bytes_seen} >= hdr_len) rx_phase = PH_CHECK;
      end
      PH_CHECK: begin
        rx_phase = PH_SYNC1;
        if (xor_sum != b) begin
          released_q.push_back(status_result(ST_BADSUM));
        end else if (hdr_len == 8'd0) begin
          released_q.push_back(status_result(ST_EMPTY));
        end else begin
          n = (hdr_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(hdr_len);
          for (int k = 0; k < n; k++) begin
            r.payload_byte = frame_buf[k[IDX_W-1:0]];
            r.byte_index   = k[IDX_W-1:0];
            r.status       = ST_DATA;
            r.last         = (k == n - 1);
            released_q.push_back(r);
          end
        end
      end
      default: rx_phase = PH_SYNC1;
    endcase
  endtask

  task automatic transfer_byte(input logic [BYTE_W-1:0] b, input bit typed, input status_t st);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    // a non-sync byte while hunting for the first sync is simply dropped
    if (!(rx_phase == PH_SYNC1 && b != SYNC_BYTE)) live_items++;
    deframe_byte(b);
    if (typed) awaited_q.push_back(status_result(st));
    else foreach (released_q[i]) awaited_q.push_back(released_q[i]);
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    transfer_byte(b, 1'b0, ST_DATA);
  endtask

  // cut < len leaves the frame truncated with no check byte
  task automatic send_frame(input int len, input bit corrupt, input int cut);
    logic [7:0] sum;
    logic [7:0] d;
    sum = len[7:0];
    push_byte(SYNC_BYTE);
    push_byte(SYNC_BYTE);
    push_byte(len[7:0]);
    for (int k = 0; k < cut; k++) begin
      d   = 8'($urandom_range(0, 255));
      sum = sum ^ d;
      push_byte(d);
    end
    if (cut == len) push_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_q.size() != 0);
    burst_left = 0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // receiver back-pressure: always ready, a fixed stall pattern, or random stalls
  int          stall_cyc  = 0;
  int          stall_mode = 0;
  logic [15:0] stall_pat  = 16'b1011_0110_1110_0101;

  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 256 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= stall_pat[stall_cyc[3:0]];
      default: out_ch.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    deframed_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer byte=%02h idx=%0d st=%0d last=%0b",
                                  out_ch.payload_byte, out_ch.byte_index,
                                  out_ch.status, out_ch.last));
      end else begin
        want = awaited_q.pop_front();
        if (out_ch.payload_byte !== want.payload_byte)
          report_mismatch($sformatf("payload_byte got %02h want %02h",
                                    out_ch.payload_byte, want.payload_byte));
        if (out_ch.byte_index !== want.byte_index)
          report_mismatch($sformatf("byte_index got %0d want %0d",
                                    out_ch.byte_index, want.byte_index));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_ch.status, want.status));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", out_ch.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("sync_length_xor_deframer_core_tb failed");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int len;
    int frames;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    rst_n         <= 1'b0;
    rx_phase   = PH_SYNC1;
    hdr_len    = '0;
    bytes_seen = '0;
    xor_sum    = '0;
    frames     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      transfer_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].st);
    hold_until_drained();

    live_items = 0;
    while (live_items < N_ITEMS) begin
      frames++;
      pick = $urandom_range(0, 99);
      if (frames == 3 || pick < 3) begin
        send_frame(MAX_PAYLOAD, 1'b0, MAX_PAYLOAD);
      end else if (pick < 60) begin
        len = $urandom_range(1, 8);
        send_frame(len, 1'b0, len);
      end else if (pick < 65) begin
        send_frame(0, 1'b0, 0);
      end else if (pick < 77) begin
        len = $urandom_range(0, 8);
        send_frame(len, 1'b1, len);
      end else if (pick < 83) begin
        send_frame($urandom_range(MAX_PAYLOAD + 1, 255), 1'b0, 0);
      end else if (pick < 88) begin
        len = $urandom_range(2, 8);
        send_frame(len, 1'b0, $urandom_range(0, len - 1));
      end else if (pick < 94) begin
        push_byte(SYNC_BYTE);
        push_byte(8'($urandom_range(0, 254)));
      end else begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 254)));
      end
      if (frames % 8 == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("sync_length_xor_deframer_core_tb passed");
    end else begin
      $display("sync_length_xor_deframer_core_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/core/sld_pkg.sv
rtl/core/sld_if.sv
rtl/core/sld_ctrl.sv
rtl/core/sld_datapath.sv
rtl/core/sync_length_xor_deframer_core.sv
tb/sync_length_xor_deframer_core_tb.sv
